@@ rtl/sha_pkg.sv @@
// Segment heap allocator package: sizes, payload structs, cell command codes.
// Used by every module of the block; no dependencies.
package sha_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int ADDR_BITS    = 20;
  localparam int LEN_W        = ADDR_BITS + 1;
  localparam int NEED_W       = LEN_W + 1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOFIT    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_DOUBLE   = 3'd4;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_NEXT  = 2'd1;
  localparam logic [1:0] POL_BEST  = 2'd2;
  localparam logic [1:0] POL_WORST = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic       CFG_POLICY = 1'b0;
  localparam logic       CFG_ARENA  = 1'b1;

  localparam logic [2:0] C_HOLD = 3'd0;
  localparam logic [2:0] C_ROT  = 3'd1;
  localparam logic [2:0] C_INS  = 3'd2;
  localparam logic [2:0] C_DEL  = 3'd3;
  localparam logic [2:0] C_WR   = 3'd4;
  localparam logic [2:0] C_INIT = 3'd5;

  typedef struct packed {
    logic        op;
    logic [20:0] req_bytes;
    logic [19:0] release_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [19:0] grant_offset;
    logic [6:0]  segment_total;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_W-1:0]     len;
    logic                 busy;
  } seg_t;

  typedef struct packed {
    logic [2:0]       code;
    logic [IDX_W-1:0] idx;
    seg_t             wdata;
    seg_t             idata;
  } cell_cmd_t;

endpackage

@@ rtl/sha_cell.sv @@
// One table slot of the segment chain: rotates, shifts for insert/delete, loads.
// Depends on sha_pkg.
module sha_cell import sha_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] pos,
  input  cell_cmd_t        cmd,
  input  seg_t             left,
  input  seg_t             right,
  output seg_t             seg
);

  seg_t seg_r, seg_nxt;
  logic [IDX_W:0] pos_w, idx_w;

  assign pos_w = {1'b0, pos};
  assign idx_w = {1'b0, cmd.idx};

  always_comb begin
    seg_nxt = seg_r;
    case (cmd.code)
      C_ROT: seg_nxt = right;
      C_INS: begin
        if (pos == cmd.idx) seg_nxt = cmd.wdata;
        else if (pos_w == idx_w + 1'b1) seg_nxt = cmd.idata;
        else if (pos > cmd.idx) seg_nxt = left;
      end
      C_DEL: if (pos >= cmd.idx) seg_nxt = right;
      C_WR:  if (pos == cmd.idx) seg_nxt = cmd.wdata;
      C_INIT: seg_nxt = (pos == '0) ? cmd.wdata : '0;
      default: seg_nxt = seg_r;
    endcase
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end

  assign seg = seg_r;

endmodule

@@ rtl/sha_ctrl.sv @@
// Sequencer: scans the rotating chain, decides fit or merge, issues cell edits.
// Depends on sha_pkg.
module sha_ctrl import sha_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rsp_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [20:0]      cfg_data,
  input  seg_t             head,
  output cell_cmd_t        cmd
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_DN   = 3'd5;
  localparam logic [2:0] S_DP   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        policy_r, policy_nxt;
  logic [20:0]       arena_r, arena_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  rover_r, rover_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [IDX_W-1:0]  s_r, s_nxt;
  logic              op_r, op_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [19:0]       off_r, off_nxt;

  logic              fa_r, fa_nxt, fb_r, fb_nxt;
  logic [IDX_W-1:0]  ia_r, ia_nxt, ib_r, ib_nxt;
  seg_t              ea_r, ea_nxt, eb_r, eb_nxt;
  seg_t              pr_r, pr_nxt, pv_r, pv_nxt;
  logic              nx_ok_r, nx_ok_nxt;
  seg_t              nx_r, nx_nxt;

  logic              mn_r, mn_nxt, mp_r, mp_nxt;
  logic [2:0]        wcode_r, wcode_nxt;
  logic [IDX_W-1:0]  widx_r, widx_nxt;
  seg_t              wdat_r, wdat_nxt, idat_r, idat_nxt;
  logic [2:0]        st_r, st_nxt;
  logic [19:0]       grant_r, grant_nxt;

  logic              ovld_r, ovld_nxt;
  rsp_t              odat_r, odat_nxt;

  logic [NEED_W-1:0] arena_al;
  logic [LEN_W-1:0]  len0;
  logic              valid_k, fit;
  logic              pick_b;
  seg_t              pe;
  logic [IDX_W-1:0]  pi;
  logic              pfound;
  logic [LEN_W-1:0]  rest;
  logic              split;
  logic [IDX_W-1:0]  del_idx;

  assign arena_al = ({1'b0, arena_r} + NEED_W'(3)) & ~NEED_W'(3);
  assign len0 = (arena_al > NEED_W'(1 << ADDR_BITS)) ? LEN_W'(1 << ADDR_BITS)
                                                      : arena_al[LEN_W-1:0];

  assign valid_k = {1'b0, k_r} < count_r;
  assign fit = valid_k && !head.busy && ({1'b0, head.len} >= need_r);

  assign pick_b = (policy_r == POL_NEXT) && !fa_r;
  assign pe     = pick_b ? eb_r : ea_r;
  assign pi     = pick_b ? ib_r : ia_r;
  assign pfound = fa_r || fb_r;
  assign rest   = pe.len - need_r[LEN_W-1:0];
  assign split  = rest != '0;
  assign del_idx = (state_r == S_DN) ? widx_r + 1'b1 : widx_r;

  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = ovld_r;
  assign out_data  = odat_r;

  always_comb begin
    state_nxt = state_r;
    policy_nxt = policy_r;
    arena_nxt = arena_r;
    count_nxt = count_r;
    rover_nxt = rover_r;
    k_nxt = k_r;
    s_nxt = s_r;
    op_nxt = op_r;
    need_nxt = need_r;
    off_nxt = off_r;
    fa_nxt = fa_r;
    fb_nxt = fb_r;
    ia_nxt = ia_r;
    ib_nxt = ib_r;
    ea_nxt = ea_r;
    eb_nxt = eb_r;
    pr_nxt = pr_r;
    pv_nxt = pv_r;
    nx_ok_nxt = nx_ok_r;
    nx_nxt = nx_r;
    mn_nxt = mn_r;
    mp_nxt = mp_r;
    wcode_nxt = wcode_r;
    widx_nxt = widx_r;
    wdat_nxt = wdat_r;
    idat_nxt = idat_r;
    st_nxt = st_r;
    grant_nxt = grant_r;
    ovld_nxt = ovld_r && out_stall;
    odat_nxt = odat_r;
    cmd = '0;
    cmd.code = C_HOLD;

    case (state_r)
      S_INIT: begin
        cmd.code = C_INIT;
        cmd.wdata = '{start: '0, len: len0, busy: 1'b0};
        count_nxt = CNT_W'(1);
        rover_nxt = '0;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_valid) begin
          if (cfg_index == CFG_POLICY) policy_nxt = cfg_data[1:0];
          else arena_nxt = cfg_data;
          state_nxt = S_INIT;
        end else if (in_valid) begin
          op_nxt = in_data.op;
          need_nxt = ({1'b0, in_data.req_bytes} + NEED_W'(3)) & ~NEED_W'(3);
          off_nxt = in_data.release_offset;
          s_nxt = ({1'b0, rover_r} < count_r) ? rover_r : '0;
          k_nxt = '0;
          fa_nxt = 1'b0;
          fb_nxt = 1'b0;
          nx_ok_nxt = 1'b0;
          pr_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.code = C_ROT;
        pr_nxt = head;
        if (op_r == OP_ALLOC) begin
          case (policy_r)
            POL_FIRST: if (fit && !fa_r) begin
              fa_nxt = 1'b1; ia_nxt = k_r; ea_nxt = head;
            end
            POL_NEXT: begin
              if (fit && !fa_r && k_r >= s_r) begin
                fa_nxt = 1'b1; ia_nxt = k_r; ea_nxt = head;
              end
              if (fit && !fb_r) begin
                fb_nxt = 1'b1; ib_nxt = k_r; eb_nxt = head;
              end
            end
            POL_BEST: if (fit && (!fa_r || head.len <= ea_r.len)) begin
              fa_nxt = 1'b1; ia_nxt = k_r; ea_nxt = head;
            end
            default: if (fit && (!fa_r || head.len >= ea_r.len)) begin
              fa_nxt = 1'b1; ia_nxt = k_r; ea_nxt = head;
            end
          endcase
        end else begin
          if (valid_k && !fa_r && head.start == off_r) begin
            fa_nxt = 1'b1; ia_nxt = k_r; ea_nxt = head; pv_nxt = pr_r;
          end
          if (fa_r && {1'b0, k_r} == {1'b0, ia_r} + 1'b1) begin
            nx_ok_nxt = valid_k; nx_nxt = head;
          end
        end
        k_nxt = k_r + 1'b1;
        if (k_r == IDX_W'(MAX_SEGMENTS - 1)) state_nxt = S_DEC;
      end
      S_DEC: begin
        grant_nxt = '0;
        state_nxt = S_OUT;
        if (op_r == OP_ALLOC) begin
          if (!pfound) st_nxt = ST_NOFIT;
          else if (split && count_r == CNT_W'(MAX_SEGMENTS)) st_nxt = ST_FULL;
          else begin
            st_nxt = ST_OK;
            grant_nxt = pe.start;
            wcode_nxt = split ? C_INS : C_WR;
            widx_nxt = pi;
            wdat_nxt = '{start: pe.start, len: need_r[LEN_W-1:0], busy: 1'b1};
            idat_nxt = '{start: pe.start + need_r[ADDR_BITS-1:0], len: rest, busy: 1'b0};
            count_nxt = count_r + CNT_W'(split);
            if (split && rover_r > pi) rover_nxt = rover_r + 1'b1;
            if (policy_r == POL_NEXT) rover_nxt = pi;
            state_nxt = S_WR;
          end
        end else begin
          if (!fa_r) st_nxt = ST_NOTFOUND;
          else begin
            st_nxt = ea_r.busy ? ST_OK : ST_DOUBLE;
            mp_nxt = (ia_r != '0) && !pv_r.busy;
            mn_nxt = nx_ok_r && !nx_r.busy;
            wcode_nxt = C_WR;
            widx_nxt = ia_r;
            wdat_nxt.busy = 1'b0;
            wdat_nxt.start = ea_r.start;
            wdat_nxt.len = ea_r.len + ((nx_ok_r && !nx_r.busy) ? nx_r.len : '0);
            if ((ia_r != '0) && !pv_r.busy) begin
              widx_nxt = ia_r - 1'b1;
              wdat_nxt.start = pv_r.start;
              wdat_nxt.len = wdat_nxt.len + pv_r.len;
            end
            count_nxt = count_r - CNT_W'((ia_r != '0) && !pv_r.busy)
                        - CNT_W'(nx_ok_r && !nx_r.busy);
            state_nxt = S_WR;
          end
        end
      end
      S_WR: begin
        cmd.code = wcode_r;
        cmd.idx = widx_r;
        cmd.wdata = wdat_r;
        cmd.idata = idat_r;
        if (op_r == OP_ALLOC) state_nxt = S_OUT;
        else begin
          if (mp_r) widx_nxt = widx_r + 1'b1;
          if (mn_r) state_nxt = S_DN;
          else if (mp_r) state_nxt = S_DP;
          else state_nxt = S_OUT;
        end
      end
      S_DN, S_DP: begin
        cmd.code = C_DEL;
        cmd.idx = del_idx;
        if (rover_r >= del_idx && rover_r != '0) rover_nxt = rover_r - 1'b1;
        state_nxt = (state_r == S_DN && mp_r) ? S_DP : S_OUT;
      end
      S_OUT: begin
        if (!ovld_r || !out_stall) begin
          ovld_nxt = 1'b1;
          odat_nxt = '{status: st_r, grant_offset: grant_r,
                       segment_total: 7'(count_r)};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      policy_r <= POL_FIRST;
      arena_r <= 21'd65536;
      count_r <= CNT_W'(1);
      rover_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      policy_r <= policy_nxt;
      arena_r <= arena_nxt;
      count_r <= count_nxt;
      rover_r <= rover_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    s_r <= s_nxt;
    op_r <= op_nxt;
    need_r <= need_nxt;
    off_r <= off_nxt;
    fa_r <= fa_nxt;
    fb_r <= fb_nxt;
    ia_r <= ia_nxt;
    ib_r <= ib_nxt;
    ea_r <= ea_nxt;
    eb_r <= eb_nxt;
    pr_r <= pr_nxt;
    pv_r <= pv_nxt;
    nx_ok_r <= nx_ok_nxt;
    nx_r <= nx_nxt;
    mn_r <= mn_nxt;
    mp_r <= mp_nxt;
    wcode_r <= wcode_nxt;
    widx_r <= widx_nxt;
    wdat_r <= wdat_nxt;
    idat_r <= idat_nxt;
    st_r <= st_nxt;
    grant_r <= grant_nxt;
    odat_r <= odat_nxt;
  end

endmodule

@@ rtl/segment_heap_allocator_top.sv @@
// Segment heap allocator top: sequencer plus a chain of MAX_SEGMENTS table cells.
// Depends on sha_pkg, sha_ctrl, sha_cell.
//
//   channel  handshake          payload
//   in       in_valid/in_stall  req_t (op, req_bytes, release_offset)
//   out      out_valid/out_stall rsp_t (status, grant_offset, segment_total)
//   cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Between accepts the table rotates once through the chain past the sequencer
// (one entry per cycle), the sequencer decides, then applies an in-place insert
// or write and, for a free, up to two delete shifts, then loads the result once
// the result register is free and returns to idle.
// Reset and each config write reload the table.
// The result register lets the block scan the next transaction while out stalls.
module segment_heap_allocator_top import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output rsp_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [20:0] cfg_data
);

  cell_cmd_t cmd;
  seg_t      segs [MAX_SEGMENTS];

  sha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (segs[0]),
    .cmd       (cmd)
  );

  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    sha_cell u_cell (
      .clk   (clk),
      .pos   (IDX_W'(g)),
      .cmd   (cmd),
      .left  ((g == 0) ? seg_t'('0) : segs[(g + MAX_SEGMENTS - 1) % MAX_SEGMENTS]),
      .right (segs[(g + 1) % MAX_SEGMENTS]),
      .seg   (segs[g])
    );
  end

endmodule

@@ dv/segment_heap_allocator_top_test.sv @@
// Self-checking testbench for segment_heap_allocator_top: allocate/free traffic under
// every fit policy and a range of arena settings, checked against an in-bench segment table predictor.
// Depends on sha_pkg and the segment_heap_allocator_top RTL.
module segment_heap_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sha_pkg::*;

  class heap_scoreboard;
    logic [1:0]   policy;
    logic [20:0]  arena;
    logic [19:0]  seg_off [MAX_SEGMENTS];
    logic [21:0]  seg_len [MAX_SEGMENTS];
    bit           seg_used [MAX_SEGMENTS];
    int           seg_cnt;
    int           rover;
    rsp_t         awaited [$];
    int           errors;

    function void rebuild();
      logic [21:0] len;
      len = ({1'b0, arena} + 22'd3) & ~22'd3;
      if (len > 22'h100000) len = 22'h100000;
      foreach (seg_off[k]) begin
        seg_off[k] = '0;
        seg_len[k] = '0;
        seg_used[k] = 0;
      end
      seg_len[0] = len;
      seg_cnt = 1;
      rover = 0;
    endfunction

    function void set_register(logic idx, logic [20:0] val);
      if (idx == CFG_POLICY) policy = val[1:0];
      else arena = val;
      rebuild();
    endfunction

    function void drop_entry(int r);
      for (int k = r; k + 1 < seg_cnt; k++) begin
        seg_off[k] = seg_off[k+1];
        seg_len[k] = seg_len[k+1];
        seg_used[k] = seg_used[k+1];
      end
      seg_cnt--;
      if (rover >= r && rover > 0) rover--;
    endfunction

    function bit usable(int i, logic [21:0] need);
      return !seg_used[i] && seg_len[i] >= need;
    endfunction

    function logic [2:0] allocate(logic [20:0] req, output logic [19:0] grant);
      logic [21:0] need, rest;
      int pick, j, s;
      bit found;
      need = ({1'b0, req} + 22'd3) & ~22'd3;
      pick = 0;
      found = 0;
      grant = '0;
      if (policy == POL_FIRST) begin
        for (int i = 0; i < seg_cnt && !found; i++)
          if (usable(i, need)) begin pick = i; found = 1; end
      end else if (policy == POL_NEXT) begin
        s = (rover < seg_cnt) ? rover : 0;
        for (int i = 0; i < seg_cnt && !found; i++) begin
          j = s + i;
          if (j >= seg_cnt) j -= seg_cnt;
          if (usable(j, need)) begin pick = j; found = 1; end
        end
      end else begin
        for (int i = 0; i < seg_cnt; i++) begin
          if (!usable(i, need)) continue;
          if (!found || (policy == POL_BEST && seg_len[i] <= seg_len[pick]) ||
              (policy == POL_WORST && seg_len[i] >= seg_len[pick])) begin
            pick = i;
            found = 1;
          end
        end
      end
      if (!found) return ST_NOFIT;
      rest = seg_len[pick] - need;
      if (rest != 0) begin
        if (seg_cnt >= MAX_SEGMENTS) return ST_FULL;
        for (int k = seg_cnt; k > pick + 1; k--) begin
          seg_off[k] = seg_off[k-1];
          seg_len[k] = seg_len[k-1];
          seg_used[k] = seg_used[k-1];
        end
        seg_off[pick+1] = seg_off[pick] + need[19:0];
        seg_len[pick+1] = rest;
        seg_used[pick+1] = 0;
        seg_cnt++;
        if (rover > pick) rover++;
      end
      seg_len[pick] = need;
      seg_used[pick] = 1;
      if (policy == POL_NEXT) rover = pick;
      grant = seg_off[pick];
      return ST_OK;
    endfunction

    function logic [2:0] release_block(logic [19:0] off);
      int i;
      logic [2:0] st;
      for (i = 0; i < seg_cnt; i++)
        if (seg_off[i] == off) break;
      if (i >= seg_cnt) return ST_NOTFOUND;
      st = seg_used[i] ? ST_OK : ST_DOUBLE;
      seg_used[i] = 0;
      if (i + 1 < seg_cnt && !seg_used[i+1]) begin
        seg_len[i] += seg_len[i+1];
        drop_entry(i + 1);
      end
      if (i > 0 && !seg_used[i-1]) begin
        seg_len[i-1] += seg_len[i];
        drop_entry(i);
      end
      return st;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      logic [19:0] g;
      g = '0;
      if (r.op == OP_ALLOC) e.status = allocate(r.req_bytes, g);
      else e.status = release_block(r.release_offset);
      e.grant_offset = g;
      e.segment_total = seg_cnt[6:0];
      awaited.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(rsp_t got);
      rsp_t e;
      if (awaited.size() == 0) begin
        report("unexpected transaction status", 32'(got.status), 32'd0);
        return;
      end
      e = awaited.pop_front();
      if (got.status != e.status) report("status", 32'(got.status), 32'(e.status));
      if (got.grant_offset != e.grant_offset)
        report("grant_offset", 32'(got.grant_offset), 32'(e.grant_offset));
      if (got.segment_total != e.segment_total)
        report("segment_total", 32'(got.segment_total), 32'(e.segment_total));
    endtask
  endclass

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  req_t        in_data;
  logic        out_valid;
  logic        out_stall;
  rsp_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [20:0] cfg_data;

  heap_scoreboard sb;
  bit quiet;
  bit hold_request;
  int cycles;

  segment_heap_allocator_top u_top (.*);

  initial begin
    clk = 0;
    sb = new();
    sb.policy = POL_FIRST;
    sb.arena = 21'd65536;
    sb.rebuild();
  end

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);

  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1;
        for (n = 0; n < 3000; n++) @(negedge clk);
        hold_request = 0;
        out_stall = 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall = 1;
        n = $urandom_range(1, 9);
        repeat (n) @(negedge clk);
        out_stall = 0;
      end
    end
  end

  task automatic send_request(req_t r);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    in_data = r;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_request(r);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic wait_drained();
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_register(logic idx, logic [20:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.set_register(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic req_t make_alloc(logic [20:0] sz);
    req_t r;
    r = '0;
    r.op = OP_ALLOC;
    r.req_bytes = sz;
    return r;
  endfunction

  function automatic req_t make_free(logic [19:0] off);
    req_t r;
    r = '0;
    r.op = OP_FREE;
    r.release_offset = off;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int lim, pick, tries;
    r = '0;
    if ($urandom_range(0, 4) == 0) begin
      r.op = 1'($urandom_range(0, 1));
      r.req_bytes = 21'($urandom_range(0, 2097151));
      r.release_offset = 20'($urandom);
    end else if ($urandom_range(0, 1) == 0) begin
      lim = sb.arena;
      if (lim > 1048576) lim = 1048576;
      if ($urandom_range(0, 7) == 0) r = make_alloc(21'($urandom_range(0, lim)));
      else r = make_alloc(21'($urandom_range(0, lim / 32 + 8)));
    end else begin
      pick = $urandom_range(0, sb.seg_cnt - 1);
      for (tries = 0; tries < 8 && !sb.seg_used[pick]; tries++)
        pick = $urandom_range(0, sb.seg_cnt - 1);
      r = make_free(sb.seg_off[pick]);
    end
    return r;
  endfunction

  initial begin
    logic [1:0]  policies [10] = '{POL_FIRST, POL_NEXT, POL_BEST, POL_WORST, POL_NEXT,
                                   POL_FIRST, POL_BEST, POL_WORST, POL_NEXT, POL_FIRST};
    logic [20:0] arenas [10] = '{21'd65536, 21'd4096, 21'd1048576, 21'h1FFFFF, 21'd0,
                                 21'd3, 21'd256, 21'd4096, 21'd65536, 21'd1048573};
    int waited;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = CFG_POLICY;
    cfg_data = '0;
    quiet = 0;
    hold_request = 0;
    repeat (9) @(negedge clk);
    rst_n = 1;

    // reset table: one free 64 KiB segment, first fit
    send_request(make_alloc(21'd0));
    send_request(make_alloc(21'd1));
    send_request(make_alloc(21'd6));
    send_request(make_alloc(21'h1FFFFF));
    send_request(make_alloc(21'd1048576));
    send_request(make_free(20'd0));
    send_request(make_free(20'd0));
    send_request(make_free(20'd12345));
    send_request(make_free(20'hFFFFF));
    send_request(make_free(20'd4));
    send_request(make_free(20'd4));
    send_request(make_alloc(21'd65536));
    send_request(make_alloc(21'd4));
    send_request(make_free(20'd0));
    send_request(make_alloc(21'd65532));
    send_request(make_alloc(21'd0));
    send_request(make_free(20'd0));
    for (int i = 0; i < 5; i++) send_request(random_request());

    for (int ph = 0; ph < 10; ph++) begin
      wait_drained();
      write_register(CFG_POLICY, {19'd0, policies[ph]});
      write_register(CFG_ARENA, arenas[ph]);
      if (ph == 9) quiet = 1;
      for (int i = 0; i < 150; i++) begin
        if (ph == 2 && i == 20) hold_request = 1;
        send_request(random_request());
      end
    end

    waited = 0;
    while (sb.awaited.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

@@ segment_heap_allocator_top.f @@
rtl/sha_pkg.sv
rtl/sha_cell.sv
rtl/sha_ctrl.sv
rtl/segment_heap_allocator_top.sv
dv/segment_heap_allocator_top_test.sv
